[hdl/bcdtz_pkg.sv]
// Shared types, constants and conversion helpers for the BCD clock timezone converter.
`default_nettype none

package bcdtz_pkg;

	localparam logic CFG_TZ_OFFSET = 1'b0;
	localparam logic CFG_DST_ENABLE = 1'b1;

	localparam int SECS_PER_DAY = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int DEVICE_ZONE_SECS = 9 * SECS_PER_HOUR;
	localparam int DAYS_LEAP_YEAR = 366;
	localparam int DAYS_PLAIN_YEAR = 365;
	localparam int DAYS_PER_QUAD = 3 * DAYS_PLAIN_YEAR + DAYS_LEAP_YEAR;
	localparam int DAYS_PER_CENTURY = 25 * DAYS_PER_QUAD;
	localparam int MONTH_MAX = 12;
	localparam int YEAR_MAX = 99;

	// reciprocal multipliers: secs * HOUR_RECIP >> 27, rem * MIN_RECIP >> 17
	localparam int HOUR_RECIP = 37283;
	localparam int MIN_RECIP = 2185;

	typedef struct packed {
		logic       opcode;
		logic [7:0] year_bcd;
		logic [4:0] month_bcd;
		logic [5:0] day_bcd;
		logic [5:0] hour_bcd;
		logic [6:0] minute_bcd;
		logic [6:0] second_bcd;
	} req_t;

	typedef struct packed {
		logic [7:0] out_year_bcd;
		logic [4:0] out_month_bcd;
		logic [5:0] out_day_bcd;
		logic [5:0] out_hour_bcd;
		logic [6:0] out_minute_bcd;
		logic [6:0] out_second_bcd;
		logic       century_wrap;
	} res_t;

	typedef struct packed {
		logic [10:0] tz_offset_minutes;
		logic        dst_enable;
	} cfg_t;

	function automatic logic [7:0] bcd2bin(input logic [7:0] v);
		return 8'({4'd0, v[7:4]} * 8'd10 + {4'd0, v[3:0]});
	endfunction

	// values below 100
	function automatic logic [7:0] bin2bcd(input logic [6:0] v);
		logic [17:0] p;
		logic [3:0]  t;
		logic [6:0]  u;
		p = 18'(v) * 18'd205;
		t = p[14:11];
		u = v - 7'(t) * 7'd10;
		return {t, u[3:0]};
	endfunction

	function automatic logic [8:0] days_before(input logic lp, input logic [3:0] m);
		logic [8:0] base;
		case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd334;
		endcase
		return (m >= 4'd3) ? base + {8'd0, lp} : base;
	endfunction

endpackage

`default_nettype wire

[hdl/bcdtz_core.sv]
// Sequencer and shared datapath: BCD time to day count and seconds, offset, back to BCD.
`default_nettype none

module bcdtz_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire bcdtz_pkg::req_t  req,
	input  wire bcdtz_pkg::cfg_t  cfg,
	output logic                  busy,
	output logic                  done,
	output bcdtz_pkg::res_t       res
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_CALC = 11'b000_0000_0010,
		S_NORM = 11'b000_0000_0100,
		S_WRAP = 11'b000_0000_1000,
		S_YBLK = 11'b000_0001_0000,
		S_YEAR = 11'b000_0010_0000,
		S_MON  = 11'b000_0100_0000,
		S_HOUR = 11'b000_1000_0000,
		S_MINA = 11'b001_0000_0000,
		S_MINB = 11'b010_0000_0000,
		S_SEC  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	bcdtz_pkg::req_t req_q;
	bcdtz_pkg::res_t res_q;
	logic signed [16:0] days_q;
	logic signed [19:0] sod_q;
	logic [15:0] rem_q;
	logic [6:0]  oy_q;
	logic [3:0]  om_q;
	logic        wrap_q;
	logic [4:0]  hr_q;
	logic [11:0] rs_q;
	logic [5:0]  mn_q;

	logic [7:0]  yv, mv, dv, hv, mnv, sv;
	logic [3:0]  mc;
	logic [16:0] days_u;
	logic [17:0] hms;
	logic signed [11:0] off;
	logic signed [17:0] off_ext, offsec, shift;
	logic signed [19:0] sod_calc;
	logic        norm_neg, norm_pos;
	logic        blk_take, year_take, mon_take;
	logic [8:0]  ylen;
	logic        olp;
	logic [32:0] hprod;
	logic [23:0] mprod;
	logic [11:0] sec_w;

	assign yv  = bcdtz_pkg::bcd2bin(req_q.year_bcd);
	assign mv  = bcdtz_pkg::bcd2bin({3'd0, req_q.month_bcd});
	assign dv  = bcdtz_pkg::bcd2bin({2'd0, req_q.day_bcd});
	assign hv  = bcdtz_pkg::bcd2bin({2'd0, req_q.hour_bcd});
	assign mnv = bcdtz_pkg::bcd2bin({1'b0, req_q.minute_bcd});
	assign sv  = bcdtz_pkg::bcd2bin({1'b0, req_q.second_bcd});
	assign mc  = (mv > 8'(bcdtz_pkg::MONTH_MAX)) ? 4'(bcdtz_pkg::MONTH_MAX) : mv[3:0];

	assign days_u = 17'(yv) * 17'(bcdtz_pkg::DAYS_PLAIN_YEAR)
		+ 17'((9'(yv) + 9'd3) >> 2)
		+ 17'(bcdtz_pkg::days_before(yv[1:0] == 2'd0, mc))
		+ 17'(dv);

	assign hms = 18'(hv) * 18'(bcdtz_pkg::SECS_PER_HOUR) + 18'(mnv) * 18'd60 + 18'(sv);

	assign off = $signed({cfg.tz_offset_minutes[10], cfg.tz_offset_minutes})
		+ (cfg.dst_enable ? 12'sd60 : 12'sd0);
	assign off_ext = {{6{off[11]}}, off};
	assign offsec = off_ext * 18'sd60;
	assign shift = req_q.opcode ? (18'(bcdtz_pkg::DEVICE_ZONE_SECS) - offsec)
		: (offsec - 18'(bcdtz_pkg::DEVICE_ZONE_SECS));
	assign sod_calc = $signed({2'b00, hms}) + {{2{shift[17]}}, shift};

	assign norm_neg = sod_q[19];
	assign norm_pos = sod_q >= 20'(bcdtz_pkg::SECS_PER_DAY);

	assign blk_take = (rem_q >= 16'(bcdtz_pkg::DAYS_PER_QUAD)) && (oy_q < 7'd96);
	assign ylen = (oy_q[1:0] == 2'd0) ? 9'(bcdtz_pkg::DAYS_LEAP_YEAR)
		: 9'(bcdtz_pkg::DAYS_PLAIN_YEAR);
	assign year_take = (rem_q >= 16'(ylen)) && (oy_q < 7'(bcdtz_pkg::YEAR_MAX));
	assign olp = (oy_q[1:0] == 2'd0);
	assign mon_take = (om_q < 4'(bcdtz_pkg::MONTH_MAX))
		&& (rem_q >= 16'(bcdtz_pkg::days_before(olp, om_q + 4'd1)));

	assign hprod = 33'(sod_q[16:0]) * 33'(bcdtz_pkg::HOUR_RECIP);
	assign mprod = 24'(rs_q) * 24'(bcdtz_pkg::MIN_RECIP);
	assign sec_w = rs_q - 12'(mn_q) * 12'd60;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (go) state_d = S_CALC;
			S_CALC: state_d = S_NORM;
			S_NORM: if (!norm_neg && !norm_pos) state_d = S_WRAP;
			S_WRAP: state_d = S_YBLK;
			S_YBLK: if (!blk_take) state_d = S_YEAR;
			S_YEAR: if (!year_take) state_d = S_MON;
			S_MON:  if (!mon_take) state_d = S_HOUR;
			S_HOUR: state_d = S_MINA;
			S_MINA: state_d = S_MINB;
			S_MINB: state_d = S_SEC;
			S_SEC:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_SEC);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (go) req_q <= req;
			end
			S_CALC: begin
				days_q <= $signed(days_u) - 17'sd1;
				sod_q  <= sod_calc;
			end
			S_NORM: begin
				if (norm_neg) begin
					sod_q  <= sod_q + 20'(bcdtz_pkg::SECS_PER_DAY);
					days_q <= days_q - 17'sd1;
				end else if (norm_pos) begin
					sod_q  <= sod_q - 20'(bcdtz_pkg::SECS_PER_DAY);
					days_q <= days_q + 17'sd1;
				end
			end
			S_WRAP: begin
				oy_q <= 7'd0;
				if (days_q[16]) begin
					rem_q  <= 16'(days_q + 17'(bcdtz_pkg::DAYS_PER_CENTURY));
					wrap_q <= 1'b1;
				end else if (days_q >= 17'(bcdtz_pkg::DAYS_PER_CENTURY)) begin
					rem_q  <= 16'(days_q - 17'(bcdtz_pkg::DAYS_PER_CENTURY));
					wrap_q <= 1'b1;
				end else begin
					rem_q  <= days_q[15:0];
					wrap_q <= 1'b0;
				end
			end
			S_YBLK: begin
				if (blk_take) begin
					rem_q <= rem_q - 16'(bcdtz_pkg::DAYS_PER_QUAD);
					oy_q  <= oy_q + 7'd4;
				end
			end
			S_YEAR: begin
				om_q <= 4'd1;
				if (year_take) begin
					rem_q <= rem_q - 16'(ylen);
					oy_q  <= oy_q + 7'd1;
				end
			end
			S_MON: begin
				if (mon_take) om_q <= om_q + 4'd1;
				else rem_q <= rem_q - 16'(bcdtz_pkg::days_before(olp, om_q));
			end
			S_HOUR: hr_q <= hprod[31:27];
			S_MINA: rs_q <= 12'(sod_q[16:0] - 17'(hr_q) * 17'(bcdtz_pkg::SECS_PER_HOUR));
			S_MINB: mn_q <= mprod[22:17];
			S_SEC: begin
				res_q.out_year_bcd   <= bcdtz_pkg::bin2bcd(oy_q);
				res_q.out_month_bcd  <= 5'(bcdtz_pkg::bin2bcd(7'(om_q)));
				res_q.out_day_bcd    <= 6'(bcdtz_pkg::bin2bcd(rem_q[6:0] + 7'd1));
				res_q.out_hour_bcd   <= 6'(bcdtz_pkg::bin2bcd(7'(hr_q)));
				res_q.out_minute_bcd <= 7'(bcdtz_pkg::bin2bcd(7'(mn_q)));
				res_q.out_second_bcd <= 7'(bcdtz_pkg::bin2bcd(sec_w[6:0]));
				res_q.century_wrap   <= wrap_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

[hdl/bcd_clock_timezone_converter_unit.sv]
// Top level of the BCD clock timezone converter: config registers, core, checks.
`default_nettype none

// channel   ports                       transfer
// request   start, busy, request        start && !busy
// result    done, result                one-cycle strobe, cannot be held off
// config    cfg_we, cfg_index, cfg_data write when cfg_we is high
//
// The time a request takes from accept to the done strobe depends on its value:
// the sequencer repeats its day normalizing, four-year steps, single-year steps
// and month steps, each as often as the value needs.
// busy goes high after accept and is low again in the cycle the result is shown.
// Reset clears the sequencer and sets the offset to 0 and daylight saving off.
// The receiver cannot stall: done is a one-cycle strobe and is never held.

module bcd_clock_timezone_converter_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bcdtz_pkg::req_t  request,
	output logic                  done,
	output bcdtz_pkg::res_t       result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [10:0]      cfg_data
);

	bcdtz_pkg::cfg_t cfg_q;
	logic            go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcdtz_pkg::CFG_TZ_OFFSET:  cfg_q.tz_offset_minutes <= cfg_data;
				bcdtz_pkg::CFG_DST_ENABLE: cfg_q.dst_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign go = start && !busy;

	bcdtz_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (request),
		.cfg    (cfg_q),
		.busy   (busy),
		.done   (done),
		.res    (result)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_month_bcd != 5'h00) && (result.out_month_bcd <= 5'h12)
			&& (result.out_month_bcd[3:0] <= 4'd9))
		else $error("result month out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_hour_bcd <= 6'h23) && (result.out_hour_bcd[3:0] <= 4'd9))
		else $error("result hour out of range");
`endif

endmodule

`default_nettype wire
